// File: rtl/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg
// Types and constants shared by the helix bracket pairing block.
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int CHAR_W  = 8;
  localparam int POS_W   = 14;
  localparam int DEPTH_W = 11;
  localparam int HLEN_W  = 15;

  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNMATCHED = 2'd1,
    ST_STACK_OVF = 2'd2,
    ST_POS_OVF   = 2'd3
  } status_t;

  typedef struct packed {
    logic              first;
    logic [CHAR_W-1:0] base_char;
    logic [CHAR_W-1:0] helix_char;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]   base_position;
    logic [POS_W-1:0]   column;
    logic [CHAR_W-1:0]  nucleotide;
    logic [DEPTH_W-1:0] nesting_depth;
    logic               partner_valid;
    logic [DEPTH_W-1:0] max_depth;
    status_t            status;
  } result_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } stk_req_t;

endpackage

// File: rtl/hbp_in_reg.sv
// ----------------------------------------------------------------------------
// hbp_in_reg
// Input register: holds one column request until the pairing stage takes it.
// ----------------------------------------------------------------------------
module hbp_in_reg
  import hbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     take,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: rtl/hbp_stack.sv
// ----------------------------------------------------------------------------
// hbp_stack
// Pair stack storage: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hbp_stack
  import hbp_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  stk_req_t         req,
  input  logic [AW-1:0]    wr_addr,
  input  logic [POS_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [POS_W-1:0] rd_data
);

  logic [POS_W-1:0] mem [DEPTH];
  logic [POS_W-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/hbp_pair_ctrl.sv
// ----------------------------------------------------------------------------
// hbp_pair_ctrl
// Column and base counters, stack pointer and depth tracking; builds the
// result fields and the stack push or pop for one column.
// ----------------------------------------------------------------------------
module hbp_pair_ctrl
  import hbp_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int MAX_BASES   = 16384,
  localparam int AW    = $clog2(STACK_DEPTH),
  localparam int SP_W  = $clog2(STACK_DEPTH + 1),
  localparam int CNT_W = $clog2(MAX_BASES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          item,
  input  logic              adv,
  input  logic [HLEN_W-1:0] helix_len,
  output result_t           res,
  output logic              res_keep,
  output stk_req_t          stk,
  output logic [AW-1:0]     wr_addr,
  output logic [POS_W-1:0]  wr_data,
  output logic [AW-1:0]     rd_addr
);

  localparam logic [31:0] LAST_POS = 32'(MAX_BASES - 1);

  logic [SP_W-1:0]  sp_r, sp_nxt, dp_r, dp_nxt, sp_c, dp_c, sp_dec;
  logic [CNT_W-1:0] bc_r, bc_nxt, cc_r, cc_nxt, bc_c, cc_c;
  logic             gap, ovf, in_helix, is_open, is_close, push_ok, pop_ok;
  logic [31:0]      pos_w, col_w, depth_w, maxd_w;

  always_comb begin
    sp_c = item.first ? '0 : sp_r;
    dp_c = item.first ? '0 : dp_r;
    bc_c = item.first ? '0 : bc_r;
    cc_c = item.first ? '0 : cc_r;

    gap      = (item.base_char == CH_DASH) || (item.base_char == CH_DOT);
    ovf      = (bc_c >= CNT_W'(MAX_BASES)) || (cc_c >= CNT_W'(MAX_BASES));
    in_helix = 32'(cc_c) < 32'(helix_len);
    is_open  = item.helix_char == CH_OPEN;
    is_close = item.helix_char == CH_CLOSE;
    push_ok  = in_helix && is_open && (sp_c < SP_W'(STACK_DEPTH));
    pop_ok   = in_helix && is_close && (sp_c != '0);
    sp_dec   = sp_c - SP_W'(1);

    sp_nxt = sp_c;
    dp_nxt = dp_c;
    bc_nxt = bc_c;
    cc_nxt = (cc_c < CNT_W'(MAX_BASES)) ? cc_c + CNT_W'(1) : cc_c;
    if (!gap && !ovf) begin
      bc_nxt = bc_c + CNT_W'(1);
      if (push_ok) begin
        sp_nxt = sp_c + SP_W'(1);
      end else if (pop_ok) begin
        sp_nxt = sp_dec;
      end
      if (in_helix && (sp_nxt > dp_c)) begin
        dp_nxt = sp_nxt;
      end
    end

    stk.wr_en = adv && !gap && !ovf && push_ok;
    stk.rd_en = adv && !gap && !ovf && pop_ok;
    wr_addr   = sp_c[AW-1:0];
    rd_addr   = sp_dec[AW-1:0];
    pos_w     = 32'(bc_c);
    col_w     = 32'(cc_c);
    wr_data   = pos_w[POS_W-1:0];
    res_keep  = !gap;

    depth_w = '0;
    if (in_helix) begin
      depth_w = push_ok ? 32'(sp_nxt) : 32'(sp_c);
    end
    maxd_w = 32'(dp_nxt);

    res.nucleotide = item.base_char;
    res.max_depth  = maxd_w[DEPTH_W-1:0];
    if (ovf) begin
      res.base_position = LAST_POS[POS_W-1:0];
      res.column        = LAST_POS[POS_W-1:0];
      res.nesting_depth = '0;
      res.partner_valid = 1'b0;
      res.status        = ST_POS_OVF;
    end else begin
      res.base_position = pos_w[POS_W-1:0];
      res.column        = col_w[POS_W-1:0];
      res.nesting_depth = depth_w[DEPTH_W-1:0];
      res.partner_valid = pop_ok;
      res.status        = ST_OK;
      if (in_helix && is_open && !push_ok) begin
        res.status = ST_STACK_OVF;
      end else if (in_helix && is_close && !pop_ok) begin
        res.status = ST_UNMATCHED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
      dp_r <= '0;
      bc_r <= '0;
      cc_r <= '0;
    end else if (adv) begin
      sp_r <= sp_nxt;
      dp_r <= dp_nxt;
      bc_r <= bc_nxt;
      cc_r <= cc_nxt;
    end
  end

endmodule

// File: rtl/helix_bracket_pairing.sv
// ----------------------------------------------------------------------------
// helix_bracket_pairing
// Pairs bases of an aligned sequence against a helix bracket mask.
// ----------------------------------------------------------------------------
// One alignment column is taken every cycle while the output is not stalled.
// A column passes an input register and then a result register on its way
// to the output; gap columns produce no result. Each column does at most one
// stack access (push or pop), and the pop's registered read lands together
// with the result register, so the stack access does not slow the column
// rate. The pair stack needs no clearing after reset: a pop only reads an
// entry written by an earlier push. Input tuser carries the start-of-sequence
// flag.
// ----------------------------------------------------------------------------
module helix_bracket_pairing
  import hbp_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int MAX_BASES   = 16384
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [HLEN_W-1:0] cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // base_char, helix_char
  input  logic [0:0]        in_tuser,   // first
  output logic              out_tvalid,
  input  logic              out_tready,
  // base_position, column, nucleotide, nesting_depth, partner_position,
  // max_depth
  output logic [71:0]       out_tdata,
  output logic [2:0]        out_tuser   // partner_valid, status
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic [HLEN_W-1:0] helix_len_r;
  in_item_t          in_item, item;
  logic              item_valid, adv, res_keep;
  result_t           res, res_r;
  stk_req_t          stk;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [POS_W-1:0]  wr_data, rd_data, partner;
  logic              out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      helix_len_r <= '0;
    end else if (cfg_wr_en) begin
      helix_len_r <= cfg_wr_data;
    end
  end

  assign in_item.first      = in_tuser[0];
  assign in_item.base_char  = in_tdata[7:0];
  assign in_item.helix_char = in_tdata[15:8];

  assign adv = item_valid && (!out_valid_r || out_tready);

  hbp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  hbp_pair_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_BASES   (MAX_BASES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .adv       (adv),
    .helix_len (helix_len_r),
    .res       (res),
    .res_keep  (res_keep),
    .stk       (stk),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr)
  );

  hbp_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .req     (stk),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register, partner comes from the stack read register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_keep;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_keep) begin
      res_r <= res;
    end
  end

  assign partner    = res_r.partner_valid ? rd_data : '0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.max_depth, partner, res_r.nesting_depth,
                       res_r.nucleotide, res_r.column, res_r.base_position};
  assign out_tuser  = {res_r.status, res_r.partner_valid};

endmodule

// File: rtl/hbp_checker.sv
// ----------------------------------------------------------------------------
// hbp_checker
// Port-level checks for the helix bracket pairing block, bound to the top.
// ----------------------------------------------------------------------------
module hbp_checker
  import hbp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [2:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_partner_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == ST_OK)
    else $error("partner reported with error status");

  a_pos_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == ST_POS_OVF |-> out_tdata[46:36] == '0 && !out_tuser[0])
    else $error("position overflow with depth or partner");

  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[46:36] <= out_tdata[71:61])
    else $error("nesting depth above max depth");

endmodule

bind helix_bracket_pairing hbp_checker u_hbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/tb_helix_bracket_pairing.sv
// ----------------------------------------------------------------------------
// tb_helix_bracket_pairing
// Self-checking testbench for the helix bracket pairing block.
// ----------------------------------------------------------------------------
// Columns are streamed into the block while a scoreboard predicts each kept
// base's result from its own copy of the pair stack and counters. Results are
// compared field by field in order. Directed columns cover gaps, pushes, pops,
// unmatched closes, other mask characters, a fresh sequence with an open
// stack, columns outside the helix and a full stack. Random bracket sequences
// follow under several helix lengths, with random idle on both sides and one
// long output stall.
// ----------------------------------------------------------------------------
module tb_helix_bracket_pairing;
  import hbp_pkg::*;

  localparam int STACK_DEPTH  = 1024;
  localparam int MAX_BASES    = 16384;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [POS_W-1:0]   base_position;
    logic [POS_W-1:0]   column;
    logic [CHAR_W-1:0]  nucleotide;
    logic [DEPTH_W-1:0] nesting_depth;
    logic [POS_W-1:0]   partner_position;
    logic               partner_valid;
    logic [DEPTH_W-1:0] max_depth;
    status_t            status;
  } pairing_t;

  class pairing_scoreboard;
    logic [POS_W-1:0] opener_stack [STACK_DEPTH];
    int depth_now;
    int base_count;
    int column_count;
    int deepest;
    int helix_length;
    int errors;
    pairing_t expected_pairings[$];

    function void start_sequence();
      depth_now = 0;
      base_count = 0;
      column_count = 0;
      deepest = 0;
    endfunction

    function void next_column();
      if (column_count < MAX_BASES) column_count++;
    endfunction

    function void note_column(logic first, logic [CHAR_W-1:0] base, logic [CHAR_W-1:0] mask);
      pairing_t p;
      if (first) start_sequence();
      if (base == CH_DASH || base == CH_DOT) begin
        next_column();
        return;
      end
      p = '0;
      p.nucleotide = base;
      p.status = ST_OK;
      if (base_count >= MAX_BASES || column_count >= MAX_BASES) begin
        p.base_position = POS_W'(MAX_BASES - 1);
        p.column = POS_W'(MAX_BASES - 1);
        p.max_depth = DEPTH_W'(deepest);
        p.status = ST_POS_OVF;
      end else begin
        p.base_position = POS_W'(base_count);
        p.column = POS_W'(column_count);
        if (column_count < helix_length) begin
          p.nesting_depth = DEPTH_W'(depth_now);
          if (mask == CH_OPEN) begin
            if (depth_now < STACK_DEPTH) begin
              opener_stack[depth_now] = POS_W'(base_count);
              depth_now++;
              p.nesting_depth = DEPTH_W'(depth_now);
            end else begin
              p.status = ST_STACK_OVF;
            end
          end else if (mask == CH_CLOSE) begin
            if (depth_now == 0) begin
              p.status = ST_UNMATCHED;
            end else begin
              depth_now--;
              p.partner_position = opener_stack[depth_now];
              p.partner_valid = 1'b1;
            end
          end
          if (depth_now > deepest) deepest = depth_now;
        end
        p.max_depth = DEPTH_W'(deepest);
        base_count++;
      end
      next_column();
      expected_pairings.push_back(p);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_pairing(pairing_t got);
      pairing_t want;
      if (expected_pairings.size() == 0) begin
        report("result with no pending request");
        return;
      end
      want = expected_pairings.pop_front();
      check_field("base_position", got.base_position, want.base_position);
      check_field("column", got.column, want.column);
      check_field("nucleotide", got.nucleotide, want.nucleotide);
      check_field("nesting_depth", got.nesting_depth, want.nesting_depth);
      check_field("partner_position", got.partner_position, want.partner_position);
      check_field("partner_valid", got.partner_valid, want.partner_valid);
      check_field("max_depth", got.max_depth, want.max_depth);
      check_field("status", int'(got.status), int'(want.status));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [HLEN_W-1:0] cfg_wr_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;   // base_char, helix_char
  logic [0:0]        in_tuser = '0;   // first
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [71:0]       out_tdata;       // base_position, column, nucleotide,
                                      // nesting_depth, partner_position, max_depth
  logic [2:0]        out_tuser;       // partner_valid, status

  pairing_scoreboard sb = new;
  pairing_t          seen;
  int                stall_cycles = 0;
  bit                tx_busy = 1'b0;
  bit                rx_busy = 1'b0;
  bit                hold_request = 1'b0;
  logic [CHAR_W-1:0] nts [4] = '{8'h41, 8'h43, 8'h47, 8'h55};

  helix_bracket_pairing i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len(bit busy);
    int r;
    if (busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // monitor, scoreboard hookup and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_column(in_tuser[0], in_tdata[7:0], in_tdata[15:8]);
      if (out_tvalid && out_tready) begin
        seen = {out_tdata[13:0], out_tdata[27:14], out_tdata[35:28], out_tdata[46:36],
                out_tdata[60:47], out_tuser[0], out_tdata[71:61], out_tuser[2:1]};
        sb.check_pairing(seen);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // result side backpressure
  initial begin : rx_side
    int g;
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        g = gap_len(rx_busy);
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_column(logic first, logic [CHAR_W-1:0] base, logic [CHAR_W-1:0] mask);
    int g;
    g = gap_len(tx_busy);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {mask, base};
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pairings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_helix_length(int len);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= HLEN_W'(len);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.helix_length = len;
  endtask

  // mostly balanced brackets, with gaps, noise and the odd broken sequence
  task automatic random_sequence(int len);
    int opens;
    int r;
    logic [CHAR_W-1:0] b;
    logic [CHAR_W-1:0] h;
    opens = 0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 19);
      if (r < 14) b = nts[$urandom_range(0, 3)];
      else if (r < 17) b = (r == 15) ? CH_DOT : CH_DASH;
      else b = CHAR_W'($urandom_range(0, 255));
      r = $urandom_range(0, 11);
      if (r < 4) begin
        h = CH_OPEN;
        opens++;
      end else if (r < 8 && (opens > 0 || r == 7)) begin
        h = CH_CLOSE;
        if (opens > 0) opens--;
      end else if (r < 11) begin
        h = CH_DOT;
      end else begin
        h = CHAR_W'($urandom_range(0, 255));
      end
      send_column(i == 0 || $urandom_range(0, 99) == 0, b, h);
    end
  endtask

  initial begin : stimulus
    int hl [6];
    int sent;
    int len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // helix length still at its reset value
    send_column(1'b1, nts[0], CH_OPEN);
    send_column(1'b0, nts[2], CH_CLOSE);

    program_helix_length(MAX_BASES);
    send_column(1'b1, nts[0], CH_OPEN);
    send_column(1'b0, CH_DASH, CH_OPEN);
    send_column(1'b0, CH_DOT, CH_CLOSE);
    send_column(1'b0, nts[1], CH_OPEN);
    send_column(1'b0, nts[2], 8'h78);
    send_column(1'b0, nts[3], CH_CLOSE);
    send_column(1'b0, nts[0], CH_CLOSE);
    send_column(1'b0, nts[1], CH_CLOSE);
    send_column(1'b0, 8'hFF, 8'h00);
    send_column(1'b0, 8'h00, 8'hFF);
    send_column(1'b1, nts[2], CH_OPEN);
    send_column(1'b1, nts[0], CH_CLOSE);

    // brackets past the helix end are ignored
    program_helix_length(3);
    send_column(1'b1, nts[0], CH_OPEN);
    send_column(1'b0, nts[1], CH_OPEN);
    send_column(1'b0, nts[2], CH_OPEN);
    send_column(1'b0, nts[3], CH_CLOSE);
    send_column(1'b0, nts[0], CH_OPEN);

    // full stack
    program_helix_length(1100);
    tx_busy = 1'b1;
    rx_busy = 1'b1;
    for (int i = 0; i < STACK_DEPTH + 2; i++) send_column(i == 0, nts[i % 4], CH_OPEN);
    for (int i = 0; i < 3; i++) send_column(1'b0, nts[i], CH_CLOSE);

    hl[0] = MAX_BASES;
    hl[1] = $urandom_range(0, 40);
    hl[2] = MAX_BASES - 1;
    hl[3] = $urandom_range(0, MAX_BASES);
    hl[4] = 1;
    hl[5] = $urandom_range(0, 40);
    for (int ph = 0; ph < 6; ph++) begin
      program_helix_length(hl[ph]);
      tx_busy = ($urandom_range(0, 3) == 0);
      rx_busy = ($urandom_range(0, 3) == 0);
      if (ph == 1) begin
        tx_busy = 1'b1;
        hold_request = 1'b1;
      end
      sent = 0;
      while (sent < 100) begin
        len = $urandom_range(1, 60);
        random_sequence(len);
        sent += len;
      end
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hbp_pkg.sv
rtl/hbp_in_reg.sv
rtl/hbp_stack.sv
rtl/hbp_pair_ctrl.sv
rtl/helix_bracket_pairing.sv
rtl/hbp_checker.sv
tb/tb_helix_bracket_pairing.sv
